### rtl/brd_pkg.sv
// Shared types, codes and helpers for the BMP raster/RLE decoder.
// No dependencies.
package brd_pkg;

    localparam logic [12:0] C_MAX_DIM = 13'd4096;
    localparam logic [12:0] C_MIN_W   = 13'd8;
    localparam logic [12:0] C_MIN_H   = 13'd1;

    localparam logic [1:0] K_SEG  = 2'd0;
    localparam logic [1:0] K_DONE = 2'd1;
    localparam logic [1:0] K_ERR  = 2'd2;

    localparam logic [2:0] F_RGB  = 3'd4;
    localparam logic [2:0] F_RLE4 = 3'd6;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_FORMAT = 2'd2;
    localparam logic [1:0] CFG_PALSZ  = 2'd3;

    localparam logic [7:0] RC_EOL   = 8'd0;
    localparam logic [7:0] RC_EOB   = 8'd1;
    localparam logic [7:0] RC_DELTA = 8'd2;

    typedef struct packed {
        logic        operation;
        logic [7:0]  palette_index;
        logic [23:0] palette_color;
        logic [7:0]  data_byte;
        logic        end_of_data;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] column;
        logic [11:0] row;
        logic [7:0]  run_length;
        logic [23:0] first_color;
        logic [23:0] second_color;
        logic        alternate;
        logic        last_of_item;
    } t_res;

    typedef enum logic [2:0] {
        CL_PAL, CL_DROP, CL_RAW, CL_RLE, CL_BAD
    } t_class;

    typedef struct packed {
        logic   valid;
        t_class cls;
        t_item  item;
    } t_head;

    typedef struct packed {
        logic [2:0] fmt;
        logic       fin;
    } t_dec_stat;

    typedef enum logic [2:0] {
        PH_FIRST, PH_CODE, PH_DX, PH_DY, PH_ABS, PH_ABSPAD, PH_ROWPAD
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_TC, S_RAW_RD, S_RAW_PIX, S_RAW_END,
        S_RUN_RD1, S_RUN_RD2, S_RUN_RD3, S_RUN, S_ABS_RD, S_ABS_PIX,
        S_EOD, S_FLUSH
    } t_state;

    function automatic logic [12:0] sat_dim(input logic [12:0] v, input logic [12:0] lo);
        logic [12:0] r;
        r = v;
        if (v < lo) r = lo;
        if (v > C_MAX_DIM) r = C_MAX_DIM;
        return r;
    endfunction

    function automatic t_res mk_seg(input logic [12:0] col, input logic signed [13:0] row,
                                    input logic [7:0] len, input logic [23:0] c1,
                                    input logic [23:0] c2, input logic alt);
        t_res r;
        r.kind         = K_SEG;
        r.column       = col[11:0];
        r.row          = row[11:0];
        r.run_length   = len;
        r.first_color  = c1;
        r.second_color = alt ? c2 : 24'd0;
        r.alternate    = alt;
        r.last_of_item = 1'b0;
        return r;
    endfunction

    function automatic t_res mk_stat(input logic [1:0] kind);
        t_res r;
        r      = '0;
        r.kind = kind;
        return r;
    endfunction

endpackage

### rtl/brd_fifo.sv
// Small synchronous word queue with full/empty flags.
// Standalone; used for the input and result queues.
module brd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp, n_wp, n_rp;
    logic [AW:0]      r_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];
    assign n_wp    = (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
    assign n_rp    = (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) r_wp <= n_wp;
            if (rd_en) r_rp <= n_rp;
            if (wr_en && !rd_en) r_cnt <= r_cnt + 1'b1;
            else if (rd_en && !wr_en) r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule

### rtl/brd_front.sv
// Front end: input word queue and classification of the head word.
// Depends on brd_pkg and brd_fifo.
module brd_front #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  brd_pkg::t_item    i_item,
    input  brd_pkg::t_dec_stat i_stat,
    input  logic              i_pop,
    output brd_pkg::t_head    o_head
);
    import brd_pkg::*;

    logic [$bits(t_item)-1:0] rdata;
    logic                     empty;
    t_item                    head;

    brd_fifo #(.WIDTH($bits(t_item)), .DEPTH(DEPTH)) u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_wdata (i_item),
        .o_full  (full),
        .i_rd    (i_pop),
        .o_rdata (rdata),
        .o_empty (empty)
    );

    assign head = t_item'(rdata);

    always_comb begin
        o_head.valid = !empty;
        o_head.item  = head;
        if (!head.operation) o_head.cls = CL_PAL;
        else if (i_stat.fin) o_head.cls = CL_DROP;
        else if (i_stat.fmt inside {[3'd0:F_RGB]}) o_head.cls = CL_RAW;
        else if (i_stat.fmt inside {[3'd5:F_RLE4]}) o_head.cls = CL_RLE;
        else o_head.cls = CL_BAD;
    end
endmodule

### rtl/brd_back.sv
// Back end: config registers, palette memory and the decode sequencer.
// Depends on brd_pkg. Results leave through a one-word hold stage.
module brd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [12:0]        i_cfg_data,
    input  brd_pkg::t_head     i_head,
    output logic               o_pop,
    output brd_pkg::t_dec_stat o_stat,
    input  logic               i_oq_full,
    output logic               o_oq_wr,
    output brd_pkg::t_res      o_oq_data
);
    import brd_pkg::*;

    t_state r_state, n_state;
    logic [12:0] r_width, r_height, n_width, n_height;
    logic [2:0]  r_fmt, n_fmt;
    logic [8:0]  r_psize, n_psize;
    logic [23:0] r_held, n_held;
    logic [12:0] r_col, n_col;
    logic signed [13:0] r_row, n_row;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_pend, n_pend;
    logic        r_pad, n_pad;
    logic [1:0]  r_rbc, n_rbc;
    logic [15:0] r_tcb, n_tcb;
    logic        r_fin, n_fin;
    logic [7:0]  r_b, n_b;
    logic        r_eod, n_eod;
    t_class      r_cls, n_cls;
    logic [3:0]  r_shift, n_shift;
    logic [7:0]  r_idx, n_idx;
    logic        r_nib, n_nib;
    logic [23:0] r_c1, n_c1, r_c2, n_c2;
    t_res        r_hold, n_hold;
    logic        r_hold_v, n_hold_v;

    logic [23:0] r_pal [256];
    logic [23:0] r_q;
    logic [7:0]  rd_addr;
    logic        mem_we;

    logic        four, wrap, want_emit, emit_ok, go, raw_more, end_row;
    logic [3:0]  bpp;
    logic [7:0]  mask, raw_idx, run_len, pend_m1;
    logic [3:0]  raw_nshift;
    logic [12:0] col_w, room, dx_col;
    logic signed [13:0] row_w, dy_row, eol_row;
    logic [1:0]  rbc_n;
    logic [8:0]  abs_bytes;
    t_res        e_res;

    assign o_stat.fmt = r_fmt;
    assign o_stat.fin = r_fin;
    assign four       = (r_fmt == F_RLE4);
    assign bpp        = 4'd1 << r_fmt[1:0];
    assign raw_more   = (r_shift >= bpp) && (r_col < r_width);
    assign raw_nshift = r_shift - bpp;
    assign raw_idx    = (r_b >> raw_nshift) & mask;
    assign wrap       = (r_col >= r_width);
    assign col_w      = wrap ? 13'd0 : r_col;
    assign row_w      = wrap ? r_row - 14'sd1 : r_row;
    assign room       = r_width - col_w;
    assign run_len    = (room < {5'd0, r_pend}) ? room[7:0] : r_pend;
    assign pend_m1    = r_pend - 8'd1;
    assign dx_col     = r_col + {5'd0, r_b};
    assign dy_row     = r_row - $signed({6'd0, r_b});
    assign eol_row    = r_row - 14'sd1;
    assign rbc_n      = r_rbc + 2'd1;
    assign end_row    = (r_col >= r_width) && (r_pend == 8'd0);
    assign abs_bytes  = four ? ({1'b0, r_b} + 9'd1) >> 1 : {1'b0, r_b};
    assign emit_ok    = !r_hold_v || !i_oq_full;
    assign go         = !want_emit || emit_ok;
    assign mem_we     = (r_state == S_IDLE) && i_head.valid && (i_head.cls == CL_PAL);

    always_comb begin
        case (r_fmt[1:0])
            2'd0:    mask = 8'h01;
            2'd1:    mask = 8'h03;
            2'd2:    mask = 8'h0f;
            default: mask = 8'hff;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_pal[i_head.item.palette_index] <= i_head.item.palette_color;
        end
        r_q <= r_pal[rd_addr];
    end

    // emit request per state
    always_comb begin
        want_emit = 1'b0;
        case (r_state)
            S_START: begin
                if (r_cls == CL_BAD) want_emit = 1'b1;
                else if (r_cls == CL_RLE) begin
                    case (r_phase)
                        PH_CODE: want_emit = (r_pend == 8'd0) &&
                                 (((r_b == RC_EOL) && (eol_row < -14'sd1)) || (r_b == RC_EOB));
                        PH_DX:   want_emit = (dx_col > r_width);
                        PH_DY:   want_emit = (dy_row < 14'sd0);
                        default: want_emit = 1'b0;
                    endcase
                end
            end
            S_TC:      want_emit = (r_col < r_width);
            S_RAW_PIX: want_emit = 1'b1;
            S_RAW_END: want_emit = end_row && (r_row <= 14'sd0);
            S_RUN:     want_emit = (r_pend != 8'd0);
            S_ABS_PIX: want_emit = 1'b1;
            S_EOD:     want_emit = !r_fin && r_eod;
            default:   want_emit = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_head.valid && (i_head.cls == CL_RAW || i_head.cls == CL_RLE ||
                                     i_head.cls == CL_BAD)) n_state = S_START;
            end
            S_START: begin
                if (go) begin
                    if (r_cls == CL_RAW) begin
                        if (r_phase == PH_ROWPAD) n_state = S_EOD;
                        else if (r_fmt == F_RGB) n_state = (r_pend == 8'd2) ? S_TC : S_RAW_END;
                        else n_state = S_RAW_RD;
                    end else if (r_cls == CL_RLE) begin
                        if (r_phase == PH_CODE && r_pend != 8'd0) n_state = S_RUN_RD1;
                        else if (r_phase == PH_ABS) n_state = S_ABS_RD;
                        else n_state = S_EOD;
                    end else n_state = S_EOD;
                end
            end
            S_TC:      if (go) n_state = S_RAW_END;
            S_RAW_RD:  n_state = raw_more ? S_RAW_PIX : S_RAW_END;
            S_RAW_PIX: if (go) n_state = S_RAW_RD;
            S_RAW_END: if (go) n_state = S_EOD;
            S_RUN_RD1: n_state = S_RUN_RD2;
            S_RUN_RD2: n_state = four ? S_RUN_RD3 : S_RUN;
            S_RUN_RD3: n_state = S_RUN;
            S_RUN: begin
                if (r_pend == 8'd0) n_state = S_EOD;
                else if (go && row_w < 14'sd0) n_state = S_EOD;
            end
            S_ABS_RD:  n_state = S_ABS_PIX;
            S_ABS_PIX: begin
                if (go) begin
                    if (row_w < 14'sd0) n_state = S_EOD;
                    else if (!(four && !r_nib && pend_m1 != 8'd0)) n_state = S_EOD;
                end
            end
            S_EOD:     if (go) n_state = S_FLUSH;
            S_FLUSH:   if (!r_hold_v || !i_oq_full) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
        if (i_cfg_we) n_state = S_IDLE;
    end

    // datapath and outputs
    always_comb begin
        n_width = r_width;  n_height = r_height; n_fmt = r_fmt; n_psize = r_psize;
        n_held = r_held;    n_col = r_col;       n_row = r_row; n_phase = r_phase;
        n_pend = r_pend;    n_pad = r_pad;       n_rbc = r_rbc; n_tcb = r_tcb;
        n_fin = r_fin;      n_b = r_b;           n_eod = r_eod; n_cls = r_cls;
        n_shift = r_shift;  n_idx = r_idx;       n_nib = r_nib;
        n_c1 = r_c1;        n_c2 = r_c2;
        n_hold = r_hold;    n_hold_v = r_hold_v;
        o_pop = 1'b0;       o_oq_wr = 1'b0;      o_oq_data = r_hold;
        rd_addr = r_idx;
        e_res = mk_stat(K_ERR);

        case (r_state)
            S_IDLE: begin
                o_pop = i_head.valid;
                if (i_head.valid) begin
                    n_b   = i_head.item.data_byte;
                    n_eod = i_head.item.end_of_data;
                    n_cls = i_head.cls;
                end
            end
            S_START: begin
                if (go) begin
                    if (r_cls == CL_BAD) n_fin = 1'b1;
                    else if (r_cls == CL_RAW) begin
                        if (r_phase == PH_ROWPAD) begin
                            n_pend = pend_m1;
                            if (pend_m1 == 8'd0) begin
                                n_row = eol_row; n_col = '0; n_rbc = '0; n_phase = PH_FIRST;
                            end
                        end else if (r_fmt == F_RGB) begin
                            if (r_pend == 8'd0) begin
                                n_tcb = {8'd0, r_b}; n_pend = 8'd1;
                            end else if (r_pend == 8'd1) begin
                                n_tcb = {r_b, r_tcb[7:0]}; n_pend = 8'd2;
                            end
                        end else n_shift = 4'd8;
                    end else begin
                        case (r_phase)
                            PH_FIRST: begin
                                n_pend = r_b; n_phase = PH_CODE;
                            end
                            PH_CODE: begin
                                n_phase = PH_FIRST;
                                if (r_pend == 8'd0) begin
                                    if (r_b == RC_EOL) begin
                                        n_row = eol_row; n_col = '0;
                                        if (eol_row < -14'sd1) n_fin = 1'b1;
                                    end else if (r_b == RC_EOB) begin
                                        e_res = mk_stat(K_DONE); n_fin = 1'b1;
                                    end else if (r_b == RC_DELTA) n_phase = PH_DX;
                                    else begin
                                        n_pend = r_b; n_pad = abs_bytes[0]; n_phase = PH_ABS;
                                    end
                                end
                            end
                            PH_DX: begin
                                n_col = dx_col; n_phase = PH_DY;
                                if (dx_col > r_width) n_fin = 1'b1;
                            end
                            PH_DY: begin
                                n_row = dy_row; n_phase = PH_FIRST;
                                if (dy_row < 14'sd0) n_fin = 1'b1;
                            end
                            PH_ABS:  n_phase = PH_ABS;
                            default: n_phase = PH_FIRST;
                        endcase
                    end
                end
            end
            S_TC: begin
                if (go) begin
                    n_held = {r_b, r_tcb};
                    n_pend = 8'd0;
                    e_res  = mk_seg(r_col, r_row, 8'd1, {r_b, r_tcb}, 24'd0, 1'b0);
                    if (r_col < r_width) n_col = r_col + 13'd1;
                end
            end
            S_RAW_RD: begin
                rd_addr = raw_idx;
                if (raw_more) begin
                    n_idx = raw_idx; n_shift = raw_nshift;
                end
            end
            S_RAW_PIX: begin
                if (go) begin
                    if ({1'b0, r_idx} < r_psize) n_held = r_q;
                    e_res = mk_seg(r_col, r_row, 8'd1,
                                   ({1'b0, r_idx} < r_psize) ? r_q : r_held, 24'd0, 1'b0);
                    n_col = r_col + 13'd1;
                end
            end
            S_RAW_END: begin
                if (go) begin
                    n_rbc = rbc_n;
                    if (end_row) begin
                        if (r_row <= 14'sd0) begin
                            e_res = mk_stat(K_DONE); n_fin = 1'b1;
                        end else if (rbc_n != 2'd0) begin
                            n_pend = 8'(3'd4 - {1'b0, rbc_n}); n_phase = PH_ROWPAD;
                        end else begin
                            n_row = eol_row; n_col = '0; n_rbc = '0; n_phase = PH_FIRST;
                        end
                    end
                end
            end
            S_RUN_RD1: rd_addr = four ? {4'd0, r_b[7:4]} : r_b;
            S_RUN_RD2: begin
                n_c1 = r_q; n_c2 = '0;
                rd_addr = {4'd0, r_b[3:0]};
            end
            S_RUN_RD3: n_c2 = r_q;
            S_RUN: begin
                if (go && r_pend != 8'd0) begin
                    n_col = col_w; n_row = row_w;
                    if (row_w < 14'sd0) n_fin = 1'b1;
                    else begin
                        e_res  = mk_seg(col_w, row_w, run_len, r_c1, r_c2, four);
                        n_col  = col_w + {5'd0, run_len};
                        n_pend = r_pend - run_len;
                        if (four && run_len[0]) begin
                            n_c1 = r_c2; n_c2 = r_c1;
                        end
                    end
                end
            end
            S_ABS_RD: begin
                rd_addr = four ? {4'd0, r_b[7:4]} : r_b;
                n_nib = 1'b0;
            end
            S_ABS_PIX: begin
                // keep the current pixel's entry on r_q while stalled
                if (four && (r_nib || go)) rd_addr = {4'd0, r_b[3:0]};
                else rd_addr = four ? {4'd0, r_b[7:4]} : r_b;
                if (go) begin
                    n_col = col_w; n_row = row_w;
                    if (row_w < 14'sd0) n_fin = 1'b1;
                    else begin
                        e_res  = mk_seg(col_w, row_w, 8'd1, r_q, 24'd0, 1'b0);
                        n_col  = col_w + 13'd1;
                        n_pend = pend_m1;
                        if (four && !r_nib && pend_m1 != 8'd0) n_nib = 1'b1;
                        else if (pend_m1 == 8'd0) n_phase = r_pad ? PH_ABSPAD : PH_FIRST;
                    end
                end
            end
            S_EOD: if (go && want_emit) n_fin = 1'b1;
            S_FLUSH: begin
                if (r_hold_v && !i_oq_full) begin
                    o_oq_wr = 1'b1;
                    o_oq_data.last_of_item = 1'b1;
                    n_hold_v = 1'b0;
                end
            end
            default: n_hold_v = r_hold_v;
        endcase

        if (want_emit && go) begin
            if (r_hold_v) begin
                o_oq_wr = 1'b1;
                o_oq_data.last_of_item = 1'b0;
            end
            n_hold   = e_res;
            n_hold_v = 1'b1;
        end

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:  n_width  = sat_dim(i_cfg_data, C_MIN_W);
                CFG_HEIGHT: n_height = sat_dim(i_cfg_data, C_MIN_H);
                CFG_FORMAT: n_fmt    = i_cfg_data[2:0];
                CFG_PALSZ:  n_psize  = i_cfg_data[8:0];
                default:    n_fmt    = r_fmt;
            endcase
            n_held = '0; n_col = '0; n_row = $signed({1'b0, n_height}) - 14'sd1;
            n_phase = PH_FIRST; n_pend = '0; n_pad = 1'b0; n_rbc = '0;
            n_tcb = '0; n_fin = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_width  <= C_MIN_W;
            r_height <= C_MIN_H;
            r_fmt    <= 3'd3;
            r_psize  <= 9'd256;
            r_held   <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_phase  <= PH_FIRST;
            r_pend   <= '0;
            r_pad    <= 1'b0;
            r_rbc    <= '0;
            r_tcb    <= '0;
            r_fin    <= 1'b0;
            r_hold_v <= 1'b0;
            r_nib    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_width  <= n_width;
            r_height <= n_height;
            r_fmt    <= n_fmt;
            r_psize  <= n_psize;
            r_held   <= n_held;
            r_col    <= n_col;
            r_row    <= n_row;
            r_phase  <= n_phase;
            r_pend   <= n_pend;
            r_pad    <= n_pad;
            r_rbc    <= n_rbc;
            r_tcb    <= n_tcb;
            r_fin    <= n_fin;
            r_hold_v <= n_hold_v;
            r_nib    <= n_nib;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b     <= n_b;
        r_eod   <= n_eod;
        r_cls   <= n_cls;
        r_shift <= n_shift;
        r_idx   <= n_idx;
        r_c1    <= n_c1;
        r_c2    <= n_c2;
        r_hold  <= n_hold;
    end
endmodule

### rtl/bmp_raster_rle_decoder.sv
// Top level of the BMP raster/RLE decoder: input queue, decode back end, result queue.
// Depends on brd_pkg, brd_fifo, brd_front and brd_back.
//
// Input words enter through push/full; results leave through empty/pop, oldest first.
// A palette word writes one color entry and yields no result. A raster byte yields
// zero or more segment words and possibly one done/error status; last_of_item marks
// the final result of a byte. Configuration is written through i_cfg_we/idx/data;
// the user must write it only while the block is idle (not enforced by the block);
// each write restarts decoding (palette kept). Raw palettized bytes alternate a
// palette read and a pixel step; an RLE run reads its palette entry before its
// segments, an RLE4 run reads a second entry for the low nibble. The sequencer
// handles one byte at a time. The last result of a byte is held until the byte
// ends so it can carry last_of_item.
// Reset empties both queues and loads width 8, height 1, 8 bpp, 256 entries.
// When the receiver stalls the result queue fills, the sequencer waits, then the
// input queue fills and full rises.
module bmp_raster_rle_decoder #(
    parameter int IQ_DEPTH = 2,
    parameter int OQ_DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  brd_pkg::t_item i_item,
    output logic           empty,
    input  logic           pop,
    output brd_pkg::t_res  o_result,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [12:0]    i_cfg_data
);
    import brd_pkg::*;

    t_head                   head;
    t_dec_stat               stat;
    logic                    front_pop;
    logic                    oq_full, oq_wr;
    t_res                    oq_data;
    logic [$bits(t_res)-1:0] oq_rdata;

    brd_front #(.DEPTH(IQ_DEPTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .i_stat  (stat),
        .i_pop   (front_pop),
        .o_head  (head)
    );

    brd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_head     (head),
        .o_pop      (front_pop),
        .o_stat     (stat),
        .i_oq_full  (oq_full),
        .o_oq_wr    (oq_wr),
        .o_oq_data  (oq_data)
    );

    brd_fifo #(.WIDTH($bits(t_res)), .DEPTH(OQ_DEPTH)) u_oq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (oq_wr),
        .i_wdata (oq_data),
        .o_full  (oq_full),
        .i_rd    (pop),
        .o_rdata (oq_rdata),
        .o_empty (empty)
    );

    assign o_result = t_res'(oq_rdata);

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        oq_wr |-> !oq_full) else $error("result pushed into full queue");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_pop |-> head.valid) else $error("pop from empty input queue");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty) else $error("result queue not empty after reset");
endmodule

### tb/sv/brd_checker.sv
// Scoreboard for bmp_raster_rle_decoder: watches the input, result and config ports,
// predicts the result words of each accepted input word and compares them in order.
// Depends on brd_pkg.
`timescale 1ns / 1ps

module brd_checker
    import brd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  t_item       i_item,
    input  logic        i_empty,
    input  logic        i_pop,
    input  t_res        i_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);

    int          img_w, img_h, pal_size;
    logic [2:0]  pix_fmt;

    logic [23:0] color_mem [256];
    logic [23:0] held;
    int          col, row, pend, row_bytes;
    t_phase      phase;
    logic        abs_pad, done_flag;
    logic [15:0] bgr_acc;

    t_res        step_q[$];
    t_res        seg_q[$];
    int          n_err, n_ok;

    function automatic int eff_w();
        return int'(sat_dim(img_w[12:0], C_MIN_W));
    endfunction

    function automatic void restart_decode();
        held      = '0;
        col       = 0;
        row       = int'(sat_dim(img_h[12:0], C_MIN_H)) - 1;
        phase     = PH_FIRST;
        pend      = 0;
        abs_pad   = 1'b0;
        row_bytes = 0;
        bgr_acc   = '0;
        done_flag = 1'b0;
    endfunction

    function automatic void add_seg(int len, logic [23:0] c1, logic [23:0] c2, logic alt);
        t_res r;
        r.kind         = K_SEG;
        r.column       = col[11:0];
        r.row          = row[11:0];
        r.run_length   = len[7:0];
        r.first_color  = c1;
        r.second_color = alt ? c2 : 24'd0;
        r.alternate    = alt;
        r.last_of_item = 1'b0;
        step_q.push_back(r);
    endfunction

    function automatic void add_status(logic [1:0] k);
        t_res r;
        r      = '0;
        r.kind = k;
        step_q.push_back(r);
        done_flag = 1'b1;
    endfunction

    function automatic logic rle_pixel(logic [23:0] c);
        if (col >= eff_w()) begin
            col = 0;
            row--;
        end
        if (row < 0) begin
            add_status(K_ERR);
            return 1'b0;
        end
        add_seg(1, c, 24'd0, 1'b0);
        col++;
        return 1'b1;
    endfunction

    function automatic void rle_run(int n, logic [23:0] c1, logic [23:0] c2, logic alt);
        int          w, len;
        logic [23:0] t;
        w = eff_w();
        while (n > 0) begin
            if (col >= w) begin
                col = 0;
                row--;
            end
            if (row < 0) begin
                add_status(K_ERR);
                return;
            end
            len = w - col;
            if (len > n) len = n;
            add_seg(len, c1, c2, alt);
            col += len;
            n   -= len;
            if (alt && len[0]) begin
                t  = c1;
                c1 = c2;
                c2 = t;
            end
        end
    endfunction

    function automatic void next_row();
        row--;
        col       = 0;
        row_bytes = 0;
        phase     = PH_FIRST;
    endfunction

    function automatic void raw_byte(logic [7:0] b);
        int w, bpp, mask, sh, idx;
        w = eff_w();
        if (phase == PH_ROWPAD) begin
            if (pend > 0) pend--;
            if (pend == 0) next_row();
            return;
        end
        if (pix_fmt == F_RGB) begin
            if (pend == 0) begin
                bgr_acc = {8'd0, b};
                pend    = 1;
            end else if (pend == 1) begin
                bgr_acc[15:8] = b;
                pend          = 2;
            end else begin
                held = {b, bgr_acc};
                pend = 0;
                if (col < w) begin
                    add_seg(1, held, 24'd0, 1'b0);
                    col++;
                end
            end
        end else begin
            bpp  = 1 << pix_fmt;
            mask = (1 << bpp) - 1;
            sh   = 8;
            while (sh >= bpp && col < w) begin
                sh -= bpp;
                idx = (int'(b) >> sh) & mask;
                if (idx < pal_size) held = color_mem[idx];
                add_seg(1, held, 24'd0, 1'b0);
                col++;
            end
        end
        row_bytes = (row_bytes + 1) & 3;
        if (col >= w && pend == 0) begin
            if (row <= 0) add_status(K_DONE);
            else if (row_bytes != 0) begin
                pend  = 4 - row_bytes;
                phase = PH_ROWPAD;
            end else next_row();
        end
    endfunction

    function automatic void rle_byte(logic [7:0] b);
        logic four;
        int   nb;
        four = (pix_fmt == F_RLE4);
        case (phase)
            PH_FIRST: begin
                pend  = b;
                phase = PH_CODE;
            end
            PH_CODE: begin
                phase = PH_FIRST;
                if (pend != 0) begin
                    if (four) rle_run(pend, color_mem[b[7:4]], color_mem[b[3:0]], 1'b1);
                    else rle_run(pend, color_mem[b], 24'd0, 1'b0);
                end else if (b == RC_EOL) begin
                    row--;
                    col = 0;
                    if (row < -1) add_status(K_ERR);
                end else if (b == RC_EOB) begin
                    add_status(K_DONE);
                end else if (b == RC_DELTA) begin
                    phase = PH_DX;
                end else begin
                    nb      = four ? (int'(b) + 1) >> 1 : int'(b);
                    pend    = b;
                    abs_pad = nb[0];
                    phase   = PH_ABS;
                end
            end
            PH_DX: begin
                col  += b;
                phase = PH_DY;
                if (col > eff_w()) add_status(K_ERR);
            end
            PH_DY: begin
                row  -= int'(b);
                phase = PH_FIRST;
                if (row < 0) add_status(K_ERR);
            end
            PH_ABS: begin
                if (four) begin
                    if (!rle_pixel(color_mem[b[7:4]])) return;
                    pend--;
                    if (pend > 0) begin
                        if (!rle_pixel(color_mem[b[3:0]])) return;
                        pend--;
                    end
                end else begin
                    if (!rle_pixel(color_mem[b])) return;
                    pend--;
                end
                if (pend == 0) phase = abs_pad ? PH_ABSPAD : PH_FIRST;
            end
            default: phase = PH_FIRST;
        endcase
    endfunction

    function automatic void predict_word(t_item it);
        step_q.delete();
        if (!it.operation) begin
            color_mem[it.palette_index] = it.palette_color;
            return;
        end
        if (done_flag) return;
        if (pix_fmt <= F_RGB) raw_byte(it.data_byte);
        else if (pix_fmt <= F_RLE4) rle_byte(it.data_byte);
        else add_status(K_ERR);
        if (!done_flag && it.end_of_data) add_status(K_ERR);
        if (step_q.size() > 0) step_q[$].last_of_item = 1'b1;
        foreach (step_q[k]) seg_q.push_back(step_q[k]);
    endfunction

    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            img_w    = 8;
            img_h    = 1;
            pix_fmt  = 3'd3;
            pal_size = 256;
            foreach (color_mem[k]) color_mem[k] = '0;
            restart_decode();
            seg_q.delete();
            n_err = 0;
            n_ok  = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WIDTH:  img_w    = i_cfg_data;
                    CFG_HEIGHT: img_h    = i_cfg_data;
                    CFG_FORMAT: pix_fmt  = i_cfg_data[2:0];
                    CFG_PALSZ:  pal_size = i_cfg_data[8:0];
                    default: ;
                endcase
                restart_decode();
            end
            if (i_push && !i_full) predict_word(i_item);
            if (i_pop && !i_empty) begin
                if (seg_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("%0t: unexpected result word %h", $realtime, i_result);
                end else begin
                    e = seg_q.pop_front();
                    if (i_result.kind !== e.kind || i_result.column !== e.column ||
                        i_result.row !== e.row || i_result.run_length !== e.run_length ||
                        i_result.first_color !== e.first_color ||
                        i_result.second_color !== e.second_color ||
                        i_result.alternate !== e.alternate ||
                        i_result.last_of_item !== e.last_of_item) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("%0t: mismatch exp k%0d x%0d y%0d n%0d %h %h a%0d l%0d",
                                $realtime, e.kind, e.column, e.row, e.run_length,
                                e.first_color, e.second_color, e.alternate,
                                e.last_of_item, "\n         got k%0d x%0d y%0d n%0d %h %h a%0d l%0d",
                                i_result.kind, i_result.column, i_result.row,
                                i_result.run_length, i_result.first_color,
                                i_result.second_color, i_result.alternate,
                                i_result.last_of_item);
                    end else n_ok++;
                end
            end
        end
        o_errors  <= n_err;
        o_checked <= n_ok;
        o_pending <= seg_q.size();
    end

endmodule

### tb/sv/testbench.sv
// Top of the decoder testbench: clock, reset, palette and raster stimulus, config
// phases, result pop with stalls, watchdog and verdict. Depends on brd_pkg,
// brd_checker and bmp_raster_rle_decoder.
`timescale 1ns / 1ps

module testbench;
    import brd_pkg::*;

    localparam logic [2:0] FMT_1BPP  = 3'd0;
    localparam logic [2:0] FMT_2BPP  = 3'd1;
    localparam logic [2:0] FMT_4BPP  = 3'd2;
    localparam logic [2:0] FMT_8BPP  = 3'd3;
    localparam logic [2:0] FMT_RLE8  = 3'd5;
    localparam logic [2:0] FMT_BAD   = 3'd7;
    localparam int         IDLE_LIMIT = 5000;
    localparam int         PAL_USED   = 32;

    logic        i_clk, i_rst_n, push, full, empty, pop, i_cfg_we;
    t_item       i_item;
    t_res        o_result;
    logic [1:0]  i_cfg_idx;
    logic [12:0] i_cfg_data;
    int          n_errors, n_pending, n_checked;
    int          bytes_sent, idle_cycles, stall_left, calm_left, images;
    logic        calm;
    logic [7:0]  raster_q[$];

    bmp_raster_rle_decoder u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_item(i_item),
        .empty(empty), .pop(pop), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    brd_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_full(full), .i_item(i_item),
        .i_empty(empty), .i_pop(pop), .i_result(o_result), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(n_errors), .o_pending(n_pending), .o_checked(n_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: short and long stalls, with stall-free stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop        <= 1'b0;
            stall_left <= 0;
            calm       <= 1'b0;
            calm_left  <= 300;
        end else begin
            if (calm_left == 0) begin
                calm      <= ~calm;
                calm_left <= $urandom_range(100, 600);
            end else calm_left <= calm_left - 1;
            if (stall_left > 0) begin
                pop        <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                pop <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                               : $urandom_range(1, 3);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || i_cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // color index byte limited to the loaded palette entries
    function automatic logic [7:0] idx_byte();
        return 8'($urandom_range(0, PAL_USED - 1));
    endfunction

    task automatic send_word(t_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (it.operation) bytes_sent++;
    endtask

    task automatic send_color(logic [7:0] idx, logic [23:0] c);
        t_item it;
        it               = '0;
        it.operation     = 1'b0;
        it.palette_index = idx;
        it.palette_color = c;
        it.data_byte     = 8'($urandom());
        it.end_of_data   = 1'($urandom_range(0, 1));
        send_word(it);
    endtask

    task automatic send_byte(logic [7:0] b, logic eod);
        t_item it;
        it               = '0;
        it.operation     = 1'b1;
        it.palette_index = 8'($urandom());
        it.palette_color = 24'($urandom());
        it.data_byte     = b;
        it.end_of_data   = eod;
        send_word(it);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic configure(logic [12:0] w, logic [12:0] h, logic [2:0] f, logic [12:0] ps);
        wait_idle();
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_FORMAT, {10'd0, f});
        write_reg(CFG_PALSZ, ps);
        i_cfg_we <= 1'b0;
        images++;
    endtask

    // play the queued stream; palette words mixed in, optional cut with end of data
    task automatic play(logic cut, logic eod_last);
        int n;
        n = raster_q.size();
        if (cut && n > 1) n = $urandom_range(1, n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 19) == 0) send_color(8'($urandom()), 24'($urandom()));
            send_byte(raster_q[k], (k == n - 1) && (cut || eod_last));
        end
        raster_q.delete();
    endtask

    task automatic build_raw(logic [2:0] f, int w, int h);
        int rb, padded;
        rb     = (f == F_RGB) ? 3 * w : (w * (1 << f) + 7) / 8;
        padded = (rb + 3) & ~3;
        for (int r = 0; r < h; r++)
            repeat ((r == h - 1) ? rb : padded)
                raster_q.push_back((f == FMT_8BPP) ? idx_byte() : 8'($urandom()));
    endtask

    // RLE8 streams keep every byte below the loaded palette size so that any
    // byte read as a color index stays in range
    task automatic build_rle(logic four);
        int r, n, nb;
        repeat ($urandom_range(4, 16)) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                raster_q.push_back((four && $urandom_range(0, 9) == 0) ?
                                   8'($urandom_range(1, 255)) : 8'($urandom_range(1, 30)));
                raster_q.push_back(four ? 8'($urandom()) : idx_byte());
            end else if (r < 65) begin
                n  = $urandom_range(3, 14);
                nb = four ? (n + 1) / 2 : n;
                raster_q.push_back(8'd0);
                raster_q.push_back(8'(n));
                repeat (nb) raster_q.push_back(four ? 8'($urandom()) : idx_byte());
                if (nb % 2) raster_q.push_back(8'd0);
            end else if (r < 80) begin
                raster_q.push_back(8'd0);
                raster_q.push_back(RC_EOL);
            end else if (r < 90) begin
                raster_q.push_back(8'd0);
                raster_q.push_back(RC_DELTA);
                raster_q.push_back(8'($urandom_range(0, 4)));
                raster_q.push_back(8'($urandom_range(0, 1)));
            end else raster_q.push_back(four ? 8'($urandom()) : idx_byte());
        end
        if ($urandom_range(0, 9) < 7) begin
            raster_q.push_back(8'd0);
            raster_q.push_back(RC_EOB);
        end
    endtask

    initial begin
        int          directed, w, h, ps;
        logic [2:0]  f;
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        bytes_sent  = 0;
        images      = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < PAL_USED; k++)
            send_color(8'(k), (k == 0) ? 24'h000000 :
                              (k == PAL_USED - 1) ? 24'hffffff : 24'($urandom()));

        // 4 bpp, small palette so high indices keep the previous color
        configure(8, 1, FMT_4BPP, 4);
        raster_q = '{8'h03, 8'h4f, 8'h10, 8'hf2};
        play(1'b0, 1'b0);
        // 1 bpp, two rows with row padding
        configure(8, 2, FMT_1BPP, 256);
        raster_q = '{8'ha5, 8'h00, 8'h00, 8'h00, 8'h0f};
        play(1'b0, 1'b0);
        // 24 bpp cut short
        configure(8, 1, F_RGB, 256);
        raster_q = '{8'h11, 8'h22, 8'h33, 8'hff};
        play(1'b0, 1'b1);
        // RLE8: run, delta, odd absolute with pad, end of line, run past the last row
        configure(8, 2, FMT_RLE8, 256);
        raster_q = '{8'h03, 8'h05, 8'h00, 8'h02, 8'h01, 8'h00, 8'h00, 8'h03,
                     8'h0a, 8'h0b, 8'h0c, 8'h00, 8'h00, 8'h00, 8'h0c, 8'h07};
        play(1'b0, 1'b0);
        // RLE4: alternating run, absolute, end of bitmap
        configure(8, 1, F_RLE4, 256);
        raster_q = '{8'h05, 8'h12, 8'h00, 8'h03, 8'hab, 8'hc0, 8'h00, 8'h01};
        play(1'b0, 1'b0);
        configure(8, 1, FMT_BAD, 256);
        raster_q = '{8'h00};
        play(1'b0, 1'b0);
        // oversized width and zero height saturate
        configure(13'h1fff, 0, FMT_RLE8, 0);
        raster_q = '{8'hff, 8'h09, 8'h00, 8'h01};
        play(1'b0, 1'b0);
        directed = bytes_sent;

        while (bytes_sent - directed < 200) begin
            f  = ($urandom_range(0, 99) < 3) ? FMT_BAD : 3'($urandom_range(0, 6));
            if ($urandom_range(0, 19) == 0) f = FMT_2BPP;
            if ($urandom_range(0, 19) == 0) f = FMT_8BPP;
            w  = $urandom_range(8, 20);
            h  = $urandom_range(1, 4);
            if (f > F_RGB && $urandom_range(0, 9) == 0) w = $urandom_range(8, 4096);
            if (f > F_RGB && $urandom_range(0, 19) == 0) h = $urandom_range(1, 4096);
            case ($urandom_range(0, 3))
                0: ps = 0;
                1: ps = 256;
                default: ps = $urandom_range(0, 256);
            endcase
            configure(13'(w), 13'(h), f, 13'(ps));
            if (f <= F_RGB) build_raw(f, w, h);
            else if (f <= F_RLE4) build_rle(f == F_RLE4);
            else raster_q.push_back(8'($urandom()));
            play($urandom_range(0, 4) == 0, $urandom_range(0, 2) == 0);
        end

        wait_idle();
        $display("testbench: %0d raster bytes over %0d images, %0d result words checked",
                 bytes_sent, images, n_checked);
        $display("testbench: raw 1/2/4/8/24 bpp, RLE8/RLE4, bad format, truncation covered");
        if (n_errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/brd_pkg.sv
rtl/brd_fifo.sv
rtl/brd_front.sv
rtl/brd_back.sv
rtl/bmp_raster_rle_decoder.sv
tb/sv/brd_checker.sv
tb/sv/testbench.sv
